FILE: design/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Types, constants and the saturation helper shared by the 4x4 matrix
// multiply unit.
// ----------------------------------------------------------------------------
package mm4_pkg;

	// Fixed-point format
	localparam int unsigned FRAC_BITS = 8;
	localparam int unsigned DATA_W    = 16;
	localparam int unsigned PROD_W    = 2 * DATA_W;
	// four products of full range need two guard bits
	localparam int unsigned ACC_W     = PROD_W + 2;
	localparam int unsigned DIM       = 4;
	localparam int unsigned IDX_W     = 2;

	localparam logic signed [ACC_W-1:0] C_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] C_MIN = -(ACC_W'(32768));

	typedef logic signed [DATA_W-1:0] elem_t;
	typedef logic [DIM-1:0][DATA_W-1:0] row_t;

	// Input transaction: one row of A and the matching row of B
	typedef struct packed {
		logic signed [15:0] a_e0;
		logic signed [15:0] a_e1;
		logic signed [15:0] a_e2;
		logic signed [15:0] a_e3;
		logic signed [15:0] b_e0;
		logic signed [15:0] b_e1;
		logic signed [15:0] b_e2;
		logic signed [15:0] b_e3;
	} in_t;

	// Output transaction: one row of C
	typedef struct packed {
		logic signed [15:0] c_e0;
		logic signed [15:0] c_e1;
		logic signed [15:0] c_e2;
		logic signed [15:0] c_e3;
		logic [1:0]         row_index;
		logic               saturated;
		logic               last;
	} out_t;

	// One multiply-accumulate step issued by the sequencer
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
		logic [IDX_W-1:0] k;
	} issue_t;

	// Store write request
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] row;
	} wr_t;

	// Sequencer status toward the top level
	typedef struct packed {
		logic             busy;
		logic             emit;
		logic [IDX_W-1:0] row;
	} seq_stat_t;

	// Saturated entry with its clip flag
	typedef struct packed {
		logic  sat;
		elem_t value;
	} sat_t;

	// Floor shift by FRAC_BITS, then clip to signed 16 bits
	function automatic sat_t saturate(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] sh;
		sat_t                    r;
		sh = acc >>> FRAC_BITS;
		if (sh > C_MAX) begin
			r.sat   = 1'b1;
			r.value = C_MAX[DATA_W-1:0];
		end else if (sh < C_MIN) begin
			r.sat   = 1'b1;
			r.value = C_MIN[DATA_W-1:0];
		end else begin
			r.sat   = 1'b0;
			r.value = sh[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: design/matrix_multiply_4x4_unit.sv
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_unit
// Fixed-point 4x4 matrix product C = A x B in signed Q8.8 with saturation.
// ----------------------------------------------------------------------------
// Feed rows 0..3 of A together with the same rows of B, one transaction per
// row. The first three rows are taken without stalling the input. The fourth
// row starts the product: a single 16x16 multiplier with a 34-bit accumulator
// performs all 64 multiply-accumulates one per cycle while steps are issued.
// Each product row runs its steps over j and k, drains through the read,
// multiply, accumulate and row buffer registers and is then handed to the
// output register; the input stays stalled until the last row is handed over.
// Each entry is the exact sum of four products, shifted right by FRAC_BITS
// toward minus infinity and clipped to 16 bits; a row reports saturated if
// any of its entries clipped. Result rows leave in order 0..3 through an
// output register, the fourth one marked last; a stalled output row holds
// while computation of the next row continues.
module matrix_multiply_4x4_unit import mm4_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);

	wr_t       wr;
	issue_t    issue;
	seq_stat_t stat;
	row_t      wr_a, wr_b;
	elem_t     a_s1, b_s1;
	row_t      row_c;
	logic      row_sat;
	logic      row_done;
	logic      out_free;
	logic      out_valid_q;
	out_t      out_q;

	assign wr_a = {in_data.a_e3, in_data.a_e2, in_data.a_e1, in_data.a_e0};
	assign wr_b = {in_data.b_e3, in_data.b_e2, in_data.b_e1, in_data.b_e0};

	assign out_free = !out_valid_q || !out_stall;

	mm4_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.row_done (row_done),
		.wr       (wr),
		.issue    (issue),
		.stat     (stat)
	);

	mm4_store u_store (
		.clk   (clk),
		.wr    (wr),
		.wr_a  (wr_a),
		.wr_b  (wr_b),
		.issue (issue),
		.a_s1  (a_s1),
		.b_s1  (b_s1)
	);

	mm4_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (issue),
		.a_s1     (a_s1),
		.b_s1     (b_s1),
		.row_c    (row_c),
		.row_sat  (row_sat),
		.row_done (row_done)
	);

	// Hold the output transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the finished row
	always_ff @(posedge clk) begin
		if (stat.emit) begin
			out_q.c_e0      <= row_c[0];
			out_q.c_e1      <= row_c[1];
			out_q.c_e2      <= row_c[2];
			out_q.c_e3      <= row_c[3];
			out_q.row_index <= stat.row;
			out_q.saturated <= row_sat;
			out_q.last      <= (stat.row == IDX_W'(DIM - 1));
		end
	end

	assign in_stall  = stat.busy;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	// No MAC step may run while a new row is being written
	a_no_issue_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !issue.valid)
		else $error("MAC step issued while input row accepted");

	// A finished row only appears while the block is busy
	a_row_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		row_done |-> in_stall)
		else $error("row completed while idle");

	// A loaded row is presented with a last mark matching its index
	a_emit_last: assert property (@(posedge clk) disable iff (!arst_n)
		stat.emit |=> (out_valid && (out_data.last == (out_data.row_index == 2'd3))))
		else $error("emitted row has wrong last mark");
`endif

endmodule

FILE: design/mm4_store.sv
// ----------------------------------------------------------------------------
// mm4_store
// Row-written storage for matrices A and B with a registered element read.
// ----------------------------------------------------------------------------
module mm4_store import mm4_pkg::*; (
	input  logic   clk,
	input  wr_t    wr,
	input  row_t   wr_a,
	input  row_t   wr_b,
	input  issue_t issue,
	output elem_t  a_s1,
	output elem_t  b_s1
);

	row_t left_mem  [DIM];
	row_t right_mem [DIM];

	// Write one row of each matrix per transaction
	always_ff @(posedge clk) begin
		if (wr.en) begin
			left_mem[wr.row]  <= wr_a;
			right_mem[wr.row] <= wr_b;
		end
	end

	// Read A[i][k] and B[k][j] for the issued step
	always_ff @(posedge clk) begin
		if (issue.valid) begin
			a_s1 <= left_mem[issue.i][issue.k];
			b_s1 <= right_mem[issue.k][issue.j];
		end
	end

endmodule

FILE: design/mm4_mac.sv
// ----------------------------------------------------------------------------
// mm4_mac
// Shared multiply-accumulate datapath: one product per cycle while steps are
// issued, accumulation over k, then shift and saturation into a row buffer.
// ----------------------------------------------------------------------------
module mm4_mac import mm4_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  issue_t issue,
	input  elem_t  a_s1,
	input  elem_t  b_s1,
	output row_t   row_c,
	output logic   row_sat,
	output logic   row_done
);

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] j;
		logic [IDX_W-1:0] k;
	} ctl_t;

	localparam logic [IDX_W-1:0] K_FIRST = '0;
	localparam logic [IDX_W-1:0] K_LAST  = IDX_W'(DIM - 1);
	localparam logic [IDX_W-1:0] J_LAST  = IDX_W'(DIM - 1);

	ctl_t                     ctl_s1, ctl_s2, ctl_s3;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	row_t                     row_c_q;
	logic                     row_sat_q;
	logic                     row_done_q;
	sat_t                     sat_res;

	// Advance the control alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1     <= '0;
			ctl_s2     <= '0;
			ctl_s3     <= '0;
			row_done_q <= 1'b0;
		end else begin
			ctl_s1     <= '{valid: issue.valid, j: issue.j, k: issue.k};
			ctl_s2     <= ctl_s1;
			ctl_s3     <= ctl_s2;
			row_done_q <= ctl_s3.valid && (ctl_s3.k == K_LAST) && (ctl_s3.j == J_LAST);
		end
	end

	// Multiply
	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			prod_s2 <= a_s1 * b_s1;
		end
	end

	// Accumulate over k, restarting at the first term
	assign prod_ext = ACC_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			if (ctl_s2.k == K_FIRST) begin
				acc_q <= prod_ext;
			end else begin
				acc_q <= acc_q + prod_ext;
			end
		end
	end

	// Shift, clip and drop the finished entry into the row buffer
	assign sat_res = saturate(acc_q);

	always_ff @(posedge clk) begin
		if (ctl_s3.valid && (ctl_s3.k == K_LAST)) begin
			row_c_q[ctl_s3.j] <= sat_res.value;
			if (ctl_s3.j == K_FIRST) begin
				row_sat_q <= sat_res.sat;
			end else begin
				row_sat_q <= row_sat_q | sat_res.sat;
			end
		end
	end

	assign row_c    = row_c_q;
	assign row_sat  = row_sat_q;
	assign row_done = row_done_q;

endmodule

FILE: design/mm4_seq.sv
// ----------------------------------------------------------------------------
// mm4_seq
// Sequencer: counts loaded rows, steps the shared MAC through i, j, k and
// hands each finished row to the output register.
// ----------------------------------------------------------------------------
module mm4_seq import mm4_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_free,
	input  logic      row_done,
	output wr_t       wr,
	output issue_t    issue,
	output seq_stat_t stat
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RUN   = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	localparam logic [IDX_W-1:0]   ROW_LAST  = IDX_W'(DIM - 1);
	localparam logic [2*IDX_W-1:0] STEP_LAST = '1;

	logic [1:0]         state_q;
	logic [IDX_W-1:0]   rows_loaded_q;
	logic [IDX_W-1:0]   row_q;
	logic [2*IDX_W-1:0] step_q;
	logic               accept;
	logic               emit;

	assign accept = (state_q == S_IDLE) && in_valid;
	assign emit   = (state_q == S_EMIT) && out_free;

	// Step through loading, computing, draining and emitting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			rows_loaded_q <= '0;
			row_q         <= '0;
			step_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rows_loaded_q <= rows_loaded_q + 1'b1;
						if (rows_loaded_q == ROW_LAST) begin
							state_q <= S_RUN;
							row_q   <= '0;
							step_q  <= '0;
						end
					end
				end
				S_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (row_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit) begin
						if (row_q == ROW_LAST) begin
							state_q <= S_IDLE;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= S_RUN;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign wr.en  = accept;
	assign wr.row = rows_loaded_q;

	assign issue.valid = (state_q == S_RUN);
	assign issue.i     = row_q;
	assign issue.j     = step_q[2*IDX_W-1:IDX_W];
	assign issue.k     = step_q[IDX_W-1:0];

	assign stat.busy = (state_q != S_IDLE);
	assign stat.emit = emit;
	assign stat.row  = row_q;

endmodule

FILE: bench/tb_matrix_multiply_4x4_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply_4x4_unit
// Self-checking bench for the fixed-point 4x4 matrix multiply unit.
// ----------------------------------------------------------------------------
// Row transactions of A and B go in through the input channel. Every fourth
// accepted row closes a matrix pair, and the scoreboard works out the four
// product rows from its own copy of both matrices. Each result row that
// leaves the block is compared field by field with the oldest pending row.
// A few directed pairs cover the saturation corners and the floor shift.
// Random pairs follow, with bursts of idle cycles on the input and stall
// bursts on the output. The last stretch of the run has no idling at all.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_4x4_unit;
	import mm4_pkg::*;

	localparam longint Q_MAX = 32767;
	localparam longint Q_MIN = -32768;
	localparam elem_t  Q_ONE = elem_t'(1 << FRAC_BITS);
	localparam int     RANDOM_PAIRS = 30;
	localparam int     QUIET_FROM   = 25;
	localparam int     DRAIN_CYCLES = 100;

	typedef enum {SPAN_FULL, SPAN_MODEST, SPAN_CORNER} span_t;

	// Predict product rows and check them against the block's output
	class mm4_scoreboard;
		elem_t      a_rows[4][4];
		elem_t      b_rows[4][4];
		logic [1:0] next_row;
		out_t       product_rows[$];
		int         errors;

		function new();
			next_row = 2'd0;
			errors   = 0;
		endfunction

		// Store one accepted row transaction; compute on the fourth one
		function void note_row(in_t t);
			elem_t av[4];
			elem_t bv[4];
			av = '{t.a_e0, t.a_e1, t.a_e2, t.a_e3};
			bv = '{t.b_e0, t.b_e1, t.b_e2, t.b_e3};
			for (int k = 0; k < 4; k++) begin
				a_rows[next_row][k] = av[k];
				b_rows[next_row][k] = bv[k];
			end
			if (next_row == 2'd3)
				multiply();
			next_row = next_row + 2'd1;
		endfunction

		// Exact sum of products, floor shift, clip to 16 bits
		function void multiply();
			longint acc;
			elem_t  vals[4];
			logic   sat;
			out_t   r;
			for (int i = 0; i < 4; i++) begin
				sat = 1'b0;
				for (int j = 0; j < 4; j++) begin
					acc = 0;
					for (int k = 0; k < 4; k++)
						acc += longint'(a_rows[i][k]) * longint'(b_rows[k][j]);
					acc = acc >>> FRAC_BITS;
					if (acc > Q_MAX) begin
						acc = Q_MAX;
						sat = 1'b1;
					end else if (acc < Q_MIN) begin
						acc = Q_MIN;
						sat = 1'b1;
					end
					vals[j] = elem_t'(acc);
				end
				r.c_e0      = vals[0];
				r.c_e1      = vals[1];
				r.c_e2      = vals[2];
				r.c_e3      = vals[3];
				r.row_index = i[1:0];
				r.saturated = sat;
				r.last      = (i == 3);
				product_rows.push_back(r);
			end
		endfunction

		function void compare(string name, int row, int want, int got);
			if (want != got) begin
				$display("%0t: row %0d %s expected %0d, actual %0d", $time, row, name,
					want, got);
				errors++;
			end
		endfunction

		// Check one accepted result transaction against the oldest prediction
		function void check_row(out_t got);
			out_t want;
			if (product_rows.size() == 0) begin
				$display("%0t: result row %0d arrived, expected none", $time,
					got.row_index);
				errors++;
				return;
			end
			want = product_rows.pop_front();
			compare("c_e0", want.row_index, want.c_e0, got.c_e0);
			compare("c_e1", want.row_index, want.c_e1, got.c_e1);
			compare("c_e2", want.row_index, want.c_e2, got.c_e2);
			compare("c_e3", want.row_index, want.c_e3, got.c_e3);
			compare("row_index", want.row_index, want.row_index, got.row_index);
			compare("saturated", want.row_index, want.saturated, got.saturated);
			compare("last", want.row_index, want.last, got.last);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t  in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	bit   quiet;

	mm4_scoreboard board = new();

	matrix_multiply_4x4_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	// Stall the output in random bursts, hold it open once the run goes quiet
	initial begin
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (quiet) begin
				out_stall <= 1'b0;
				@(negedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 13);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end else begin
				n = $urandom_range(1, 40);
				out_stall <= 1'b0;
				repeat (n) @(negedge clk);
			end
		end
	end

	// Check every result transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_row(out_data);
	end

	function automatic elem_t random_elem(span_t span);
		unique case (span)
			SPAN_FULL:   return elem_t'($urandom_range(0, 65535));
			SPAN_MODEST: return elem_t'(int'($urandom_range(0, 2047)) - 1024);
			default: begin
				unique case ($urandom_range(0, 4))
					0:       return elem_t'(Q_MAX);
					1:       return elem_t'(Q_MIN);
					2:       return elem_t'(0);
					3:       return elem_t'(-1);
					default: return Q_ONE;
				endcase
			end
		endcase
	endfunction

	function automatic in_t random_row(span_t span);
		return in_t'{random_elem(span), random_elem(span), random_elem(span),
			random_elem(span), random_elem(span), random_elem(span),
			random_elem(span), random_elem(span)};
	endfunction

	function automatic in_t flat_row(elem_t a, elem_t b);
		return in_t'{a, a, a, a, b, b, b, b};
	endfunction

	// Present one row and hold it until the block takes it
	task automatic send_row(input in_t row);
		in_data  <= row;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		board.note_row(row);
		@(negedge clk);
	endtask

	// Drop valid for a random burst now and then
	task automatic pause_sender();
		int n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic send_matrices(input in_t rows[4]);
		for (int r = 0; r < 4; r++) begin
			send_row(rows[r]);
			pause_sender();
		end
	endtask

	// Hold off until every predicted row has come back
	task automatic wait_drained();
		while (board.product_rows.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		in_t   rows[4];
		span_t span;
		int    pick;

		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		quiet    = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Positive clip: all entries at the maximum
		for (int r = 0; r < 4; r++) rows[r] = flat_row(elem_t'(Q_MAX), elem_t'(Q_MAX));
		send_matrices(rows);
		// Positive clip from two minimum operands
		for (int r = 0; r < 4; r++) rows[r] = flat_row(elem_t'(Q_MIN), elem_t'(Q_MIN));
		send_matrices(rows);
		// Negative clip
		for (int r = 0; r < 4; r++) rows[r] = flat_row(elem_t'(Q_MIN), elem_t'(Q_MAX));
		send_matrices(rows);
		// Identity on the left passes B through unchanged
		for (int r = 0; r < 4; r++) begin
			rows[r] = random_row(SPAN_FULL);
			rows[r].a_e0 = (r == 0) ? Q_ONE : elem_t'(0);
			rows[r].a_e1 = (r == 1) ? Q_ONE : elem_t'(0);
			rows[r].a_e2 = (r == 2) ? Q_ONE : elem_t'(0);
			rows[r].a_e3 = (r == 3) ? Q_ONE : elem_t'(0);
		end
		send_matrices(rows);
		// Small negative sums floor toward minus infinity
		for (int r = 0; r < 4; r++) rows[r] = flat_row(elem_t'(-1), elem_t'(1));
		send_matrices(rows);
		// Zero matrices
		for (int r = 0; r < 4; r++) rows[r] = flat_row(elem_t'(0), elem_t'(0));
		send_matrices(rows);

		in_valid <= 1'b0;
		wait_drained();

		// Random matrix pairs, mostly modest values that rarely clip
		for (int g = 0; g < RANDOM_PAIRS; g++) begin
			if (g >= QUIET_FROM)
				quiet = 1'b1;
			if (g == RANDOM_PAIRS / 2) begin
				in_valid <= 1'b0;
				wait_drained();
			end
			pick = $urandom_range(0, 19);
			span = (pick < 12) ? SPAN_MODEST : (pick < 17) ? SPAN_FULL : SPAN_CORNER;
			for (int r = 0; r < 4; r++) rows[r] = random_row(span);
			send_matrices(rows);
		end
		in_valid <= 1'b0;

		// Wait for the last products, then watch for strays
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
